[src/trial_division_prime_test_defines.svh]
// Assertion macros shared by the trial division prime test checker.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define TDPT_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/tdpt_pkg.sv]
// Package for the trial division prime test: widths, microcode types and program.
package tdpt_pkg;

   // Fixed field widths
   localparam int CANDIDATE_W = 16;
   localparam int RSP_DATA_W  = 8;

   // First trial divisor
   localparam int FIRST_DIVISOR = 2;

   // Step counter of the sequencer
   typedef logic [2:0] step_type;

   localparam step_type STEP_IDLE     = 3'd0;
   localparam step_type STEP_CHK_LT2  = 3'd1;
   localparam step_type STEP_CHK_SQ   = 3'd2;
   localparam step_type STEP_DIV      = 3'd3;
   localparam step_type STEP_NEXT_DIV = 3'd4;
   localparam step_type STEP_EMIT0    = 3'd5;
   localparam step_type STEP_EMIT1    = 3'd6;

   // Datapath operations
   typedef enum logic [2:0] {
      OP_NONE     = 3'd0,
      OP_LOAD     = 3'd1,
      OP_DIV_INIT = 3'd2,
      OP_DIV_STEP = 3'd3,
      OP_NEXT_DIV = 3'd4,
      OP_EMIT     = 3'd5
   } op_type;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_NEVER    = 3'd0,
      COND_IN_VALID = 3'd1,
      COND_LT2      = 3'd2,
      COND_SQ_GT    = 3'd3,
      COND_CNT_ZERO = 3'd4,
      COND_REM_NZ   = 3'd5,
      COND_OUT_FREE = 3'd6
   } cond_type;

   // One control word: taken jump goes to target, else hold or step on
   typedef struct packed {
      logic     ready;
      op_type   op;
      cond_type cond;
      step_type target;
      logic     hold;
      logic     result;
   } ctrl_word_type;

   // Microprogram ROM
   function automatic ctrl_word_type microcode(input step_type step);
      ctrl_word_type cw;
      cw = '{ready: 1'b0, op: OP_NONE, cond: COND_NEVER,
             target: STEP_IDLE, hold: 1'b0, result: 1'b0};
      unique case (step)
         STEP_IDLE: begin
            // wait for a candidate, load it with the first divisor
            cw.ready  = 1'b1;
            cw.op     = OP_LOAD;
            cw.cond   = COND_IN_VALID;
            cw.target = STEP_CHK_LT2;
            cw.hold   = 1'b1;
         end
         STEP_CHK_LT2: begin
            cw.cond   = COND_LT2;
            cw.target = STEP_EMIT0;
         end
         STEP_CHK_SQ: begin
            // divider setup is harmless when the square test exits
            cw.op     = OP_DIV_INIT;
            cw.cond   = COND_SQ_GT;
            cw.target = STEP_EMIT1;
         end
         STEP_DIV: begin
            cw.op     = OP_DIV_STEP;
            cw.cond   = COND_CNT_ZERO;
            cw.target = STEP_NEXT_DIV;
            cw.hold   = 1'b1;
         end
         STEP_NEXT_DIV: begin
            // nonzero remainder: next divisor; zero falls through to EMIT0
            cw.op     = OP_NEXT_DIV;
            cw.cond   = COND_REM_NZ;
            cw.target = STEP_CHK_SQ;
         end
         STEP_EMIT0: begin
            cw.op     = OP_EMIT;
            cw.cond   = COND_OUT_FREE;
            cw.target = STEP_IDLE;
            cw.hold   = 1'b1;
            cw.result = 1'b0;
         end
         STEP_EMIT1: begin
            cw.op     = OP_EMIT;
            cw.cond   = COND_OUT_FREE;
            cw.target = STEP_IDLE;
            cw.hold   = 1'b1;
            cw.result = 1'b1;
         end
         default: begin
            // unused step codes return to idle
            cw.cond   = COND_NEVER;
            cw.hold   = 1'b0;
            cw.target = STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

[src/trial_division_prime_test.sv]
// Trial division prime test: microcoded sequencer over a bit-serial remainder unit.
//
// Usage:
//   req_* carries one candidate per transaction (req_tdata[15:0]); only the
//   low NUMBER_WIDTH bits (at most 16) are tested. rsp_* returns one
//   transaction per candidate, rsp_tdata[0] = 1 when the number is prime.
//   One candidate is worked on at a time; req_tready is high only while the
//   sequencer sits in its idle step.
//   Zero and one go from the below-two check straight to an emit step.
//   Otherwise each trial divisor runs one square check, W remainder steps
//   of the shared divider (W = tested width) and one divisor update, with
//   entry and exit steps around them. For 16-bit inputs a large prime
//   needs 254 divisors (2 to 255).
//   The result sits in an output register: a new candidate is accepted while
//   it waits. If the receiver stalls, the sequencer holds in its emit step
//   until that register frees up.
//   Reset (synchronous, active high) returns the sequencer to idle and
//   drops rsp_tvalid.
module trial_division_prime_test #(
   parameter int NUMBER_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tdpt_pkg::CANDIDATE_W-1:0] req_tdata,   // [15:0] candidate
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tdpt_pkg::RSP_DATA_W-1:0]  rsp_tdata    // [0] is_prime, [7:1] zero
);

   // Tested width, divisor/square widths, bit counter width
   localparam int NUM_W = (NUMBER_WIDTH < tdpt_pkg::CANDIDATE_W) ?
                          NUMBER_WIDTH : tdpt_pkg::CANDIDATE_W;
   localparam int DIV_W = (NUM_W + 1) / 2 + 1;
   localparam int SQ_W  = 2 * DIV_W;
   localparam int CNT_W = $clog2(NUM_W);

   tdpt_pkg::step_type      pc_ff, pc_in;
   tdpt_pkg::ctrl_word_type cw;

   logic [NUM_W-1:0] n_ff, n_in;
   logic [DIV_W-1:0] d_ff, d_in;
   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic [DIV_W-1:0] r_ff, r_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_prime_ff, rsp_prime_in;

   logic [DIV_W:0]   shifted;
   logic             out_free;
   logic             cond_true;

   // Control word of the current step
   assign cw = tdpt_pkg::microcode(pc_ff);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign shifted  = {r_ff, n_ff[cnt_ff]};

   // Condition select
   always_comb begin
      case (cw.cond)
         tdpt_pkg::COND_NEVER:    cond_true = 1'b0;
         tdpt_pkg::COND_IN_VALID: cond_true = req_tvalid;
         tdpt_pkg::COND_LT2:      cond_true = (n_ff[NUM_W-1:1] == '0);
         tdpt_pkg::COND_SQ_GT:    cond_true = (sq_ff > SQ_W'(n_ff));
         tdpt_pkg::COND_CNT_ZERO: cond_true = (cnt_ff == '0);
         tdpt_pkg::COND_REM_NZ:   cond_true = (r_ff != '0);
         tdpt_pkg::COND_OUT_FREE: cond_true = out_free;
         default:                 cond_true = 1'b0;
      endcase
   end

   // Step sequencing
   always_comb begin
      if (cond_true) begin
         pc_in = cw.target;
      end else if (cw.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + 3'd1;
      end
   end

   // Datapath
   always_comb begin
      n_in         = n_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      r_in         = r_ff;
      cnt_in       = cnt_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (cw.op)
         tdpt_pkg::OP_LOAD: begin
            if (req_tvalid) begin
               n_in  = req_tdata[NUM_W-1:0];
               d_in  = DIV_W'(tdpt_pkg::FIRST_DIVISOR);
               sq_in = SQ_W'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
            end
         end
         tdpt_pkg::OP_DIV_INIT: begin
            r_in   = '0;
            cnt_in = CNT_W'(NUM_W - 1);
         end
         tdpt_pkg::OP_DIV_STEP: begin
            // restoring remainder, one candidate bit per cycle, MSB first
            if (shifted >= {1'b0, d_ff}) begin
               r_in = DIV_W'(shifted - {1'b0, d_ff});
            end else begin
               r_in = shifted[DIV_W-1:0];
            end
            cnt_in = cnt_ff - CNT_W'(1);
         end
         tdpt_pkg::OP_NEXT_DIV: begin
            // (d+1)^2 = d^2 + 2d + 1
            d_in  = d_ff + DIV_W'(1);
            sq_in = sq_ff + SQ_W'({d_ff, 1'b1});
         end
         tdpt_pkg::OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = cw.result;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= tdpt_pkg::STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      r_ff         <= r_in;
      cnt_ff       <= cnt_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign req_tready = cw.ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = tdpt_pkg::RSP_DATA_W'(rsp_prime_ff);

endmodule

[src/tdpt_checker.sv]
// Port-level checker for the trial division prime test, bound to the top level.
`include "trial_division_prime_test_defines.svh"

module tdpt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [tdpt_pkg::CANDIDATE_W-1:0] req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tdpt_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // A stalled result stays valid and unchanged
   `TDPT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // One candidate at a time: input closes after each transaction
   `TDPT_ASSERT_NEXT(a_req_single, req_tvalid && req_tready, !req_tready, "input stayed open after a transaction")

   // No result comes out of reset
   `TDPT_ASSERT_IMPLY(a_rsp_reset, $past(reset), !rsp_tvalid, "result valid right after reset")

   // Zero and one answer not prime, via the below-two check and the emit step, when the output is empty
   `TDPT_ASSERT_IMPLY(a_small, req_tvalid && req_tready && !rsp_tvalid && (req_tdata[15:1] == '0), ##3 (rsp_tvalid && !rsp_tdata[0]), "zero or one not reported as not prime")

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (.*);

[tb/tb.sv]
// Self-checking testbench for the trial division prime test.
module tb;

   localparam int          CANDIDATE_W     = tdpt_pkg::CANDIDATE_W;
   localparam int          RSP_DATA_W      = tdpt_pkg::RSP_DATA_W;
   localparam int          TESTED_W        = 16;
   localparam int unsigned CYCLE_LIMIT     = 4_000_000;
   localparam int          TAIL_CYCLES     = 32;
   localparam int          RANDOM_ITEMS    = 114;
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam int          MAX_REPORTS     = 10;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [CANDIDATE_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   // Idle rates in percent, and a request for a long receiver hold-off
   int          send_idle_pct = 8;
   int          recv_idle_pct = 52;
   int          hold_request  = 0;
   int unsigned cycle_count   = 0;

   // Edge cases: zero and one, two and three, small and prime squares,
   // powers of two, largest 15/16-bit primes, all ones
   logic [CANDIDATE_W-1:0] directed_set [19] = '{
      16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25, 16'd49, 16'd97,
      16'd255, 16'd257, 16'd4093, 16'd32749, 16'd32768, 16'd63001, 16'd65521,
      16'd65534, 16'd65535
   };

   typedef struct {
      logic [CANDIDATE_W-1:0] candidate;
      bit                     is_prime;
   } verdict_entry_type;

   // Predicts the verdict per candidate and checks the returned ones in order
   class prime_result_tracker;
      verdict_entry_type verdicts_due[$];
      int                mismatches = 0;

      // Plain trial division over the tested low bits
      function bit prime_by_trial_division(input logic [CANDIDATE_W-1:0] candidate);
         int unsigned n;
         int unsigned d;
         n = 32'(candidate) & ((32'd1 << TESTED_W) - 32'd1);
         if (n < 2) return 1'b0;
         for (d = 2; d * d <= n; d++) begin
            if (n % d == 0) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_candidate(input logic [CANDIDATE_W-1:0] candidate);
         verdict_entry_type entry;
         entry.candidate = candidate;
         entry.is_prime  = prime_by_trial_division(candidate);
         verdicts_due.push_back(entry);
      endfunction

      function void check_verdict(input logic [RSP_DATA_W-1:0] data);
         verdict_entry_type     entry;
         logic [RSP_DATA_W-1:0] want;
         if (verdicts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result transaction: rsp_tdata=%h", data);
            return;
         end
         entry = verdicts_due.pop_front();
         want  = RSP_DATA_W'(entry.is_prime);
         if (data !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("candidate %0d: expected rsp_tdata=%h, got %h",
                        entry.candidate, want, data);
         end
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction
   endclass

   prime_result_tracker tracker = new;

   trial_division_prime_test #(
      .NUMBER_WIDTH (TESTED_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Offer one candidate, with random idle cycles ahead of it, until accepted
   task automatic send_candidate(input logic [CANDIDATE_W-1:0] candidate);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= candidate;
      do @(posedge clock); while (!req_tready);
      tracker.note_candidate(candidate);
   endtask

   // Stop offering until every verdict has come back
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Mostly small numbers; some full range and some products of two large factors
   function automatic logic [CANDIDATE_W-1:0] random_candidate();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 25) return CANDIDATE_W'($urandom_range(65535));
      if (pick < 35) return CANDIDATE_W'($urandom_range(255, 128) * $urandom_range(255, 128));
      if (pick < 60) return CANDIDATE_W'($urandom_range(4095));
      return CANDIDATE_W'($urandom_range(255));
   endfunction

   // Result side: check each transaction, then pick the next ready
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) tracker.check_verdict(rsp_tdata);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Stimulus
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_set[i]) send_candidate(directed_set[i]);
      wait_for_drain();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 8;
               recv_idle_pct = 52;
            end
            1: begin
               send_idle_pct = 52;
               recv_idle_pct = 8;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               // long receiver stall with quick candidates: output fills, input backs up
               hold_request  = HOLD_OFF_CYCLES;
               repeat (6) send_candidate(CANDIDATE_W'($urandom_range(63)));
            end
         endcase
         repeat (RANDOM_ITEMS / 3) send_candidate(random_candidate());
         wait_for_drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/tdpt_pkg.sv
src/trial_division_prime_test.sv
src/tdpt_checker.sv
tb/tb.sv
